FILE: hdl/ffd_pkg.sv
// Shared types and constants for the fixed-length frame deframer.
// Used by ffd_ctrl, ffd_dpath and fixed_length_frame_deframer; no dependencies.
`timescale 1ns / 1ps

package ffd_pkg;

  // Beat field widths
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;
  localparam int CFG_IDX_W = 3;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_HEADER_FIRST  = 3'd0;
  localparam cfg_idx_t REG_HEADER_SECOND = 3'd1;
  localparam cfg_idx_t REG_TAIL_FIRST    = 3'd2;
  localparam cfg_idx_t REG_TAIL_SECOND   = 3'd3;

  // Register reset values
  localparam byte_t RST_HEADER_FIRST  = 8'd170;
  localparam byte_t RST_HEADER_SECOND = 8'd85;
  localparam byte_t RST_TAIL_FIRST    = 8'd13;
  localparam byte_t RST_TAIL_SECOND   = 8'd10;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  // Parser states, one-hot
  typedef enum logic [5:0] {
    ST_HEAD0 = 6'b000001,
    ST_HEAD1 = 6'b000010,
    ST_DATA  = 6'b000100,
    ST_TAIL0 = 6'b001000,
    ST_TAIL1 = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;     // store the accepted byte in the payload memory
    logic rd_en;     // read one payload entry into the drain stage
    logic rd_last;   // the entry read is the final one of the frame
    logic err_load;  // load a frame-error result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hdr_first_hit;
    logic hdr_second_hit;
    logic tail_first_hit;
    logic tail_second_hit;
    logic rd_free;   // drain stage can take a read this cycle
    logic err_ok;    // drain stage empty and output register free
  } sts_t;

endpackage

FILE: hdl/fixed_length_frame_deframer.sv
// Fixed-length frame deframer: one received byte per input beat, two-byte
// header, PAYLOAD_BYTES (1 to 64) payload bytes and a two-byte tail; a good tail
// releases the payload as PAYLOAD_BYTES beats with byte_index and last, a bad
// second tail byte gives one frame-error beat (kind 1). Header and tail values
// are set through the cfg port (index 0..3; other indexes are ignored) and
// should be written only while the block is idle. Input bytes are taken one
// per cycle while hunting and storing. The second tail byte is held off until
// the drain stage is empty and the output register is free or being taken, so
// a frame that ends while earlier results still wait stalls there. After a good
// tail the input is held off while the payload memory is read out through its
// single read port, one entry per cycle while the output does not stall;
// results pass from the read into the drain stage and then the output
// register, and the next frame's bytes are taken while the last results still
// wait. The payload memory needs no clearing after reset.
// Depends on ffd_pkg, ffd_ctrl and ffd_dpath.
`timescale 1ns / 1ps

module fixed_length_frame_deframer #(
  parameter int PAYLOAD_BYTES = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ffd_pkg::cfg_idx_t cfg_index,
  input  ffd_pkg::byte_t    cfg_data,
  // Received bytes
  input  logic              in_valid,
  output logic              in_ready,
  input  ffd_pkg::byte_t    in_rx_byte,
  // Results
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output ffd_pkg::byte_t    out_data_byte,
  output ffd_pkg::index_t   out_byte_index,
  output logic              out_last
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  ffd_pkg::cmd_t cmd;
  ffd_pkg::sts_t sts;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Registers take a write every cycle
  assign cfg_ready = 1'b1;

  ffd_ctrl #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .AW(AW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr)
  );

  ffd_dpath #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .AW(AW)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_rx_byte    (in_rx_byte),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_byte_index(out_byte_index),
    .out_last      (out_last)
  );

endmodule

FILE: hdl/ffd_ctrl.sv
// Parser state machine and payload counters of the frame deframer.
// Depends on ffd_pkg; drives commands to ffd_dpath.
`timescale 1ns / 1ps

module ffd_ctrl #(
  parameter int PAYLOAD_BYTES = 24,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ffd_pkg::sts_t sts,
  output ffd_pkg::cmd_t cmd,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(PAYLOAD_BYTES - 1);

  ffd_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   wr_cnt_r, wr_cnt_nxt;
  logic [AW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic            in_acc;

  // Hold off input while draining, and in the second tail wait until an error
  // result could be placed behind everything already queued
  always_comb begin
    case (state_r)
      ffd_pkg::ST_DRAIN: in_ready = 1'b0;
      ffd_pkg::ST_TAIL1: in_ready = sts.err_ok;
      default:           in_ready = 1'b1;
    endcase
  end

  assign in_acc  = in_valid && in_ready;
  assign wr_addr = wr_cnt_r;
  assign rd_addr = rd_cnt_r;

  // Next state, counters and commands
  always_comb begin
    state_nxt    = state_r;
    wr_cnt_nxt   = wr_cnt_r;
    rd_cnt_nxt   = rd_cnt_r;
    cmd          = '0;
    case (state_r)
      ffd_pkg::ST_HEAD0: begin
        if (in_acc && sts.hdr_first_hit) state_nxt = ffd_pkg::ST_HEAD1;
      end
      ffd_pkg::ST_HEAD1: begin
        if (in_acc) begin
          if (sts.hdr_second_hit) begin
            wr_cnt_nxt = '0;
            state_nxt  = ffd_pkg::ST_DATA;
          end else if (!sts.hdr_first_hit) begin
            state_nxt = ffd_pkg::ST_HEAD0;
          end
        end
      end
      ffd_pkg::ST_DATA: begin
        if (in_acc) begin
          cmd.wr_en = 1'b1;
          if (wr_cnt_r == LAST_ADDR) begin
            state_nxt = ffd_pkg::ST_TAIL0;
          end else begin
            wr_cnt_nxt = wr_cnt_r + 1'b1;
          end
        end
      end
      ffd_pkg::ST_TAIL0: begin
        if (in_acc) begin
          if (sts.tail_first_hit) begin
            state_nxt = ffd_pkg::ST_TAIL1;
          end else if (sts.hdr_first_hit) begin
            state_nxt = ffd_pkg::ST_HEAD1;
          end else begin
            state_nxt = ffd_pkg::ST_HEAD0;
          end
        end
      end
      ffd_pkg::ST_TAIL1: begin
        if (in_acc) begin
          if (sts.tail_second_hit) begin
            rd_cnt_nxt = '0;
            state_nxt  = ffd_pkg::ST_DRAIN;
          end else begin
            cmd.err_load = 1'b1;
            state_nxt    = ffd_pkg::ST_HEAD0;
          end
        end
      end
      ffd_pkg::ST_DRAIN: begin
        // Advance one entry whenever the drain stage has room
        if (sts.rd_free) begin
          cmd.rd_en = 1'b1;
          if (rd_cnt_r == LAST_ADDR) begin
            cmd.rd_last = 1'b1;
            state_nxt   = ffd_pkg::ST_HEAD0;
          end else begin
            rd_cnt_nxt = rd_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ffd_pkg::ST_HEAD0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ffd_pkg::ST_HEAD0;
      wr_cnt_r <= '0;
      rd_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      wr_cnt_r <= wr_cnt_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

endmodule

FILE: hdl/ffd_dpath.sv
// Datapath of the frame deframer: delimiter registers and compares, payload
// memory, drain stage and output register. Depends on ffd_pkg; run by ffd_ctrl.
`timescale 1ns / 1ps

module ffd_dpath #(
  parameter int PAYLOAD_BYTES = 24,
  parameter int AW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  ffd_pkg::cfg_idx_t cfg_index,
  input  ffd_pkg::byte_t    cfg_data,
  input  ffd_pkg::byte_t    in_rx_byte,
  input  ffd_pkg::cmd_t     cmd,
  input  logic [AW-1:0]     wr_addr,
  input  logic [AW-1:0]     rd_addr,
  output ffd_pkg::sts_t     sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output ffd_pkg::byte_t    out_data_byte,
  output ffd_pkg::index_t   out_byte_index,
  output logic              out_last
);

  ffd_pkg::byte_t  hdr_first_r, hdr_second_r, tail_first_r, tail_second_r;
  ffd_pkg::byte_t  mem [PAYLOAD_BYTES];

  ffd_pkg::byte_t  rd_data_r;
  ffd_pkg::index_t rd_index_r;
  logic            rd_last_r;
  logic            rd_vld_r;

  logic            out_valid_r;
  logic            out_kind_r;
  ffd_pkg::byte_t  out_data_r;
  ffd_pkg::index_t out_index_r;
  logic            out_last_r;

  logic            out_free;
  logic            out_load;

  // Delimiter registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r   <= ffd_pkg::RST_HEADER_FIRST;
      hdr_second_r  <= ffd_pkg::RST_HEADER_SECOND;
      tail_first_r  <= ffd_pkg::RST_TAIL_FIRST;
      tail_second_r <= ffd_pkg::RST_TAIL_SECOND;
    end else if (cfg_we) begin
      case (cfg_index)
        ffd_pkg::REG_HEADER_FIRST:  hdr_first_r   <= cfg_data;
        ffd_pkg::REG_HEADER_SECOND: hdr_second_r  <= cfg_data;
        ffd_pkg::REG_TAIL_FIRST:    tail_first_r  <= cfg_data;
        ffd_pkg::REG_TAIL_SECOND:   tail_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compare the incoming byte against each delimiter
  assign out_free = !out_valid_r || out_ready;
  assign out_load = rd_vld_r && out_free;

  always_comb begin
    sts.hdr_first_hit   = (in_rx_byte == hdr_first_r);
    sts.hdr_second_hit  = (in_rx_byte == hdr_second_r);
    sts.tail_first_hit  = (in_rx_byte == tail_first_r);
    sts.tail_second_hit = (in_rx_byte == tail_second_r);
    sts.rd_free         = !rd_vld_r || out_load;
    sts.err_ok          = !rd_vld_r && out_free;
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_index_r <= ffd_pkg::INDEX_W'(rd_addr);
      rd_last_r  <= cmd.rd_last;
    end
  end

  // Drain stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (cmd.rd_en) begin
      rd_vld_r <= 1'b1;
    end else if (out_load) begin
      rd_vld_r <= 1'b0;
    end
  end

  // Output register: error result, next payload beat, or drop the taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.err_load || out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      out_kind_r  <= ffd_pkg::KIND_ERROR;
      out_data_r  <= '0;
      out_index_r <= '0;
      out_last_r  <= 1'b1;
    end else if (out_load) begin
      out_kind_r  <= ffd_pkg::KIND_PAYLOAD;
      out_data_r  <= rd_data_r;
      out_index_r <= rd_index_r;
      out_last_r  <= rd_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data_byte  = out_data_r;
  assign out_byte_index = out_index_r;
  assign out_last       = out_last_r;

endmodule

FILE: tb/fixed_length_frame_deframer_tb.sv
// Self-checking testbench for fixed_length_frame_deframer: framed byte streams
// with broken headers and tails, a cycle-free parser model and in-order checking.
// Depends on ffd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module fixed_length_frame_deframer_tb;

  localparam int PAYLOAD_BYTES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = PAYLOAD_BYTES + 8;

  // Register index beyond the four defined ones
  localparam ffd_pkg::cfg_idx_t REG_UNUSED = 3'd6;

  // Parser phases of the model
  typedef enum logic [2:0] {
    PH_HEAD0, PH_HEAD1, PH_DATA, PH_TAIL0, PH_TAIL1
  } parse_phase_t;

  // How a generated frame ends
  typedef enum int {
    END_GOOD, END_BAD_SECOND, END_BAD_FIRST, END_BAD_FIRST_HDR
  } frame_end_t;

  typedef struct packed {
    logic            kind;
    ffd_pkg::byte_t  data_byte;
    ffd_pkg::index_t byte_index;
    logic            last;
  } result_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  ffd_pkg::cfg_idx_t cfg_index = '0;
  ffd_pkg::byte_t    cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ffd_pkg::byte_t    in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_kind;
  ffd_pkg::byte_t    out_data_byte;
  ffd_pkg::index_t   out_byte_index;
  logic              out_last;

  // Model state and register copies
  parse_phase_t   phase_q = PH_HEAD0;
  int             payload_cnt = 0;
  ffd_pkg::byte_t payload_mem [PAYLOAD_BYTES];
  ffd_pkg::byte_t hdr_first_q = ffd_pkg::RST_HEADER_FIRST;
  ffd_pkg::byte_t hdr_second_q = ffd_pkg::RST_HEADER_SECOND;
  ffd_pkg::byte_t tail_first_q = ffd_pkg::RST_TAIL_FIRST;
  ffd_pkg::byte_t tail_second_q = ffd_pkg::RST_TAIL_SECOND;

  ffd_pkg::byte_t rx_bytes_q [$];
  result_beat_t   frame_results_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int stall_cnt = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;

  fixed_length_frame_deframer #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_byte_index(out_byte_index),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // Advance the parser model by one accepted byte and queue what it releases
  task automatic parse_byte(input ffd_pkg::byte_t b);
    result_beat_t r;
    case (phase_q)
      PH_HEAD0: begin
        if (b == hdr_first_q) phase_q = PH_HEAD1;
      end
      PH_HEAD1: begin
        if (b == hdr_second_q) begin
          payload_cnt = 0;
          phase_q = PH_DATA;
        end else if (b != hdr_first_q) begin
          phase_q = PH_HEAD0;
        end
      end
      PH_DATA: begin
        if (payload_cnt < PAYLOAD_BYTES) begin
          payload_mem[payload_cnt] = b;
          payload_cnt++;
        end
        if (payload_cnt >= PAYLOAD_BYTES) phase_q = PH_TAIL0;
      end
      PH_TAIL0: begin
        if (b == tail_first_q) begin
          phase_q = PH_TAIL1;
        end else begin
          // drop the frame, resync on a header byte if it is one
          phase_q = (b == hdr_first_q) ? PH_HEAD1 : PH_HEAD0;
          payload_cnt = 0;
        end
      end
      PH_TAIL1: begin
        if (b == tail_second_q) begin
          for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            r.kind       = ffd_pkg::KIND_PAYLOAD;
            r.data_byte  = payload_mem[k];
            r.byte_index = ffd_pkg::index_t'(k);
            r.last       = (k == PAYLOAD_BYTES - 1);
            frame_results_q.push_back(r);
          end
        end else begin
          r.kind       = ffd_pkg::KIND_ERROR;
          r.data_byte  = '0;
          r.byte_index = '0;
          r.last       = 1'b1;
          frame_results_q.push_back(r);
        end
        payload_cnt = 0;
        phase_q = PH_HEAD0;
      end
      default: begin
        payload_cnt = 0;
        phase_q = PH_HEAD0;
      end
    endcase
  endtask

  // Input driver: hold a beat until accepted, then offer the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (rx_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_rx_byte <= rx_bytes_q.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each beat against the oldest expectation, drive ready
  always @(posedge clk) begin
    result_beat_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind=%0d data_byte=%02h %s",
                   $time, out_kind, out_data_byte,
                   $sformatf("byte_index=%0d last=%0d", out_byte_index, out_last));
          mismatches++;
        end else begin
          e = frame_results_q.pop_front();
          if (out_kind !== e.kind) begin
            $display("%0t: kind mismatch, expected %0d actual %0d", $time, e.kind, out_kind);
            mismatches++;
          end
          if (out_data_byte !== e.data_byte) begin
            $display("%0t: data_byte mismatch, expected %02h actual %02h",
                     $time, e.data_byte, out_data_byte);
            mismatches++;
          end
          if (out_byte_index !== e.byte_index) begin
            $display("%0t: byte_index mismatch, expected %0d actual %0d",
                     $time, e.byte_index, out_byte_index);
            mismatches++;
          end
          if (out_last !== e.last) begin
            $display("%0t: last mismatch, expected %0d actual %0d", $time, e.last, out_last);
            mismatches++;
          end
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // Write one register and mirror it into the model
  task automatic write_reg(input ffd_pkg::cfg_idx_t idx, input ffd_pkg::byte_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ffd_pkg::REG_HEADER_FIRST:  hdr_first_q = val;
      ffd_pkg::REG_HEADER_SECOND: hdr_second_q = val;
      ffd_pkg::REG_TAIL_FIRST:    tail_first_q = val;
      ffd_pkg::REG_TAIL_SECOND:   tail_second_q = val;
      default: ;
    endcase
  endtask

  function automatic ffd_pkg::byte_t byte_other_than(input ffd_pkg::byte_t v);
    ffd_pkg::byte_t r;
    do r = ffd_pkg::byte_t'($urandom_range(255)); while (r == v);
    return r;
  endfunction

  // Queue payload and tail; a pattern payload walks the bit extremes
  task automatic queue_body(input bit pattern, input frame_end_t how);
    ffd_pkg::byte_t b;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      b = ffd_pkg::byte_t'($urandom_range(255));
      if (pattern) begin
        if (i == 0) b = 8'h00;
        else if (i == 1) b = 8'hFF;
        else if (i < 10) b = 8'h01 << (i - 2);
        else if (i < 18) b = ~(8'h01 << (i - 10));
      end
      rx_bytes_q.push_back(b);
    end
    case (how)
      END_GOOD: begin
        rx_bytes_q.push_back(tail_first_q);
        rx_bytes_q.push_back(tail_second_q);
      end
      END_BAD_SECOND: begin
        rx_bytes_q.push_back(tail_first_q);
        rx_bytes_q.push_back(byte_other_than(tail_second_q));
      end
      END_BAD_FIRST: begin
        do b = byte_other_than(tail_first_q); while (b == hdr_first_q);
        rx_bytes_q.push_back(b);
      end
      default: begin
        // only meaningful when the header byte differs from the tail byte
        rx_bytes_q.push_back(hdr_first_q == tail_first_q ?
                             byte_other_than(tail_first_q) : hdr_first_q);
      end
    endcase
  endtask

  task automatic queue_frame(input bit pattern, input frame_end_t how);
    rx_bytes_q.push_back(hdr_first_q);
    rx_bytes_q.push_back(hdr_second_q);
    queue_body(pattern, how);
  endtask

  // Wait until every byte is taken and every result is back, then settle
  task automatic wait_drained();
    while (rx_bytes_q.size() > 0 || in_valid || frame_results_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) payload_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values; an out-of-range index must be ignored
    send_idle_pct = 28;
    recv_idle_pct = 87;
    write_reg(REG_UNUSED, ffd_pkg::byte_t'($urandom_range(255)));
    // repeated first header byte, then a good frame with bit-pattern payload
    rx_bytes_q.push_back(hdr_first_q);
    queue_frame(1'b1, END_GOOD);
    // other byte in the second-header wait
    rx_bytes_q.push_back(hdr_first_q);
    rx_bytes_q.push_back(8'h00);
    wait_drained();

    // Extreme register values
    send_idle_pct = 87;
    recv_idle_pct = 28;
    write_reg(ffd_pkg::REG_HEADER_FIRST, 8'h00);
    write_reg(ffd_pkg::REG_HEADER_SECOND, 8'hFF);
    write_reg(ffd_pkg::REG_TAIL_FIRST, 8'hFF);
    write_reg(ffd_pkg::REG_TAIL_SECOND, 8'h00);
    // wrong first tail byte equal to the header: straight to the second-header wait
    queue_frame(1'b0, END_BAD_FIRST_HDR);
    rx_bytes_q.push_back(hdr_second_q);
    // then a bad second tail byte
    queue_body(1'b0, END_BAD_SECOND);
    wait_drained();

    // Equal header bytes, equal tail bytes; no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(ffd_pkg::REG_HEADER_FIRST, 8'hFF);
    write_reg(ffd_pkg::REG_HEADER_SECOND, 8'hFF);
    write_reg(ffd_pkg::REG_TAIL_FIRST, 8'h00);
    write_reg(ffd_pkg::REG_TAIL_SECOND, 8'h00);
    // hold the output off while a good frame and a dropped frame push in
    hold_req = 1'b1;
    queue_frame(1'b0, END_GOOD);
    queue_frame(1'b0, END_BAD_FIRST);
    wait_drained();

    if (frame_results_q.size() > 0)
      $display("%0t: %0d expected results never arrived", $time, frame_results_q.size());
    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
